// ===== rtl/des_cbc_pkg.sv =====
// DES CBC package: permutation tables, S-boxes and helper functions.
// Used by des_cbc_block_cipher_top. No dependencies.
`default_nettype none
package des_cbc_pkg;

  localparam int unsigned BlockW  = 64;
  localparam int unsigned KeyW    = 48;
  localparam int unsigned NRounds = 16;
  localparam int unsigned RegIdxW = 2;

  typedef logic [RegIdxW-1:0] reg_idx_t;
  localparam reg_idx_t RegKey     = 2'd0;
  localparam reg_idx_t RegIv      = 2'd1;
  localparam reg_idx_t RegDecrypt = 2'd2;

  typedef logic [7:0] tab_entry_t;

  localparam tab_entry_t TabPc1 [56] = '{
    57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
    60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,
    29,21,13,5,28,20,12,4};
  localparam tab_entry_t TabPc2 [48] = '{
    14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
    41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
  localparam tab_entry_t TabIp [64] = '{
    58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,62,54,46,38,30,22,14,6,
    64,56,48,40,32,24,16,8,57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
  localparam tab_entry_t TabFp [64] = '{
    40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,38,6,46,14,54,22,62,30,
    37,5,45,13,53,21,61,29,36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
  localparam tab_entry_t TabE [48] = '{
    32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
    16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
  localparam tab_entry_t TabP [32] = '{
    16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
  // Shift amount per round: 1 or 2
  localparam logic [NRounds-1:0] RotTwo = 16'b0111111011111100;

  localparam logic [3:0] TabSbox [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,3,5,6,11,0}};

  function automatic logic [63:0] perm_ip(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(TabIp[i])];
    return r;
  endfunction

  function automatic logic [63:0] perm_fp(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(TabFp[i])];
    return r;
  endfunction

  function automatic logic [55:0] perm_pc1(input logic [63:0] v);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) r[55-i] = v[64-int'(TabPc1[i])];
    return r;
  endfunction

  function automatic logic [47:0] perm_pc2(input logic [55:0] v);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) r[47-i] = v[56-int'(TabPc2[i])];
    return r;
  endfunction

  // One Feistel function: E, subkey XOR, S-boxes, P
  function automatic logic [31:0] feistel(input logic [47:0] sk, input logic [31:0] rv);
    logic [47:0] e;
    logic [31:0] o;
    logic [31:0] p;
    logic [5:0]  six;
    for (int i = 0; i < 48; i++) e[47-i] = rv[32-int'(TabE[i])];
    e = e ^ sk;
    for (int i = 0; i < 8; i++) begin
      six = e[47-6*i -: 6];
      o[31-4*i -: 4] = TabSbox[i][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) p[31-i] = o[32-int'(TabP[i])];
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/des_cbc_block_cipher_top.sv =====
// DES CBC block cipher top level: one shared round unit run 16 times per beat.
// Depends on des_cbc_pkg.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------
//   cfg      | cfg_valid/ready    | cfg_index_i, cfg_data_i
//   in       | in_valid/ready     | data_block_i, first_block_i
//   out      | out_valid/ready    | out_block_o
//
// The input beat edge loads IP and the key halves. Output valid rises once the
// StRound states of the shared Feistel round unit and the StDone finishing state
// have passed. The next input beat is taken only after StOut returns to StIdle.
// Subkeys come from C/D shift registers rotated alongside the rounds
// (right rotation when decrypting), so no key schedule memory exists.
// Reset clears the chain and registers to zero. Input is held off while a
// block is in flight or its result waits; output stalls hold the result.
`default_nettype none
module des_cbc_block_cipher_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [63:0] data_block_i,
  input  wire logic        first_block_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      out_block_o
);

  typedef enum logic [1:0] {StIdle, StRound, StDone, StOut} state_e;

  state_e      state_q;
  logic [3:0]  rnd_q;
  logic [63:0] key_q, iv_q, chain_q, in_blk_q, out_q;
  logic        dec_q;
  logic [31:0] l_q, r_q;
  logic [27:0] c_q, d_q;
  logic [55:0] cd_init;
  logic [27:0] c_rot, d_rot;
  logic [63:0] chain_use, des_in, pre_fp;
  logic [31:0] f_out;
  logic        two;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign out_block_o = out_q;

  assign cd_init   = des_cbc_pkg::perm_pc1(key_q);
  assign chain_use = first_block_i ? iv_q : chain_q;
  assign des_in    = dec_q ? data_block_i : (data_block_i ^ chain_use);
  assign two       = des_cbc_pkg::RotTwo[rnd_q];

  // Encrypt rotates left before use; decrypt uses current key then rotates right
  always_comb begin
    if (dec_q) begin
      c_rot = c_q;
      d_rot = d_q;
    end else if (two) begin
      c_rot = {c_q[25:0], c_q[27:26]};
      d_rot = {d_q[25:0], d_q[27:26]};
    end else begin
      c_rot = {c_q[26:0], c_q[27]};
      d_rot = {d_q[26:0], d_q[27]};
    end
  end

  assign f_out  = des_cbc_pkg::feistel(des_cbc_pkg::perm_pc2({c_rot, d_rot}), r_q);
  assign pre_fp = {r_q, l_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      rnd_q    <= '0;
      key_q    <= '0;
      iv_q     <= '0;
      dec_q    <= 1'b0;
      chain_q  <= '0;
      in_blk_q <= '0;
      out_q    <= '0;
      l_q      <= '0;
      r_q      <= '0;
      c_q      <= '0;
      d_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          des_cbc_pkg::RegKey:     key_q <= cfg_data_i;
          des_cbc_pkg::RegIv:      iv_q  <= cfg_data_i;
          des_cbc_pkg::RegDecrypt: dec_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            {l_q, r_q} <= des_cbc_pkg::perm_ip(des_in);
            in_blk_q   <= data_block_i;
            chain_q    <= chain_use;
            c_q        <= cd_init[55:28];
            d_q        <= cd_init[27:0];
            rnd_q      <= '0;
            state_q    <= StRound;
          end
        end
        StRound: begin
          l_q <= r_q;
          r_q <= l_q ^ f_out;
          if (dec_q) begin
            // right rotation by the amount of round 16-i
            if (des_cbc_pkg::RotTwo[4'd15 - rnd_q]) begin
              c_q <= {c_q[1:0], c_q[27:2]};
              d_q <= {d_q[1:0], d_q[27:2]};
            end else begin
              c_q <= {c_q[0], c_q[27:1]};
              d_q <= {d_q[0], d_q[27:1]};
            end
          end else begin
            c_q <= c_rot;
            d_q <= d_rot;
          end
          rnd_q <= rnd_q + 4'd1;
          if (rnd_q == 4'd15) state_q <= StDone;
        end
        StDone: begin
          if (dec_q) begin
            out_q   <= des_cbc_pkg::perm_fp(pre_fp) ^ chain_q;
            chain_q <= in_blk_q;
          end else begin
            out_q   <= des_cbc_pkg::perm_fp(pre_fp);
            chain_q <= des_cbc_pkg::perm_fp(pre_fp);
          end
          state_q <= StOut;
        end
        StOut: begin
          if (out_ready_i) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
`default_nettype wire
